@@ sv/ppdm_pkg.sv @@
// Shared types and constants for the pulse period and duty meter.
// Holds the FSM state type, configuration register indexes and field widths.
// No dependencies.
`default_nettype none

package ppdm_pkg;

  localparam int TICK_W = 16;
  localparam int US_W   = 32;
  localparam int DUTY_W = 7;
  localparam int PRE_W  = 16;
  localparam int TPU_W  = 8;
  localparam int CFG_W  = 32;

  // Longest period that does not count, in ticks: a period must exceed it.
  localparam logic [TICK_W-1:0] MIN_TICKS = TICK_W'(3);
  localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(100);

  typedef enum logic [1:0] {
    REG_PRESCALER    = 2'd0,
    REG_QUIET_US     = 2'd1,
    REG_TICKS_PER_US = 2'd2,
    REG_FREE_RUNNING = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_WB
  } state_t;

endpackage

`default_nettype wire

@@ sv/ppdm_mul.sv @@
// Bit-serial shift-and-add multiplier unit for the pulse meter.
// Forms prescaler*new_total, prescaler*old_period and quiet_us*ticks_per_us
// one multiplier bit per cycle. Depends on ppdm_pkg.
`default_nettype none

module ppdm_mul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [ppdm_pkg::PRE_W-1:0]        prescaler,
  input  wire logic [ppdm_pkg::TICK_W-1:0]       cand_new,
  input  wire logic [ppdm_pkg::TICK_W-1:0]       cand_old,
  input  wire logic [ppdm_pkg::US_W-1:0]         quiet_us,
  input  wire logic [ppdm_pkg::TPU_W-1:0]        ticks_per_us,
  output logic      [ppdm_pkg::US_W-1:0]         prod_new,
  output logic      [ppdm_pkg::US_W-1:0]         prod_old,
  output logic      [ppdm_pkg::US_W+ppdm_pkg::TPU_W-1:0] prod_quiet,
  output logic                                   done
);

  localparam int QW = ppdm_pkg::US_W + ppdm_pkg::TPU_W;

  logic                        busy;
  logic [3:0]                  cnt;
  logic [ppdm_pkg::PRE_W-1:0]  mr;
  logic [ppdm_pkg::TPU_W-1:0]  tr;
  logic [ppdm_pkg::US_W-1:0]   m_new;
  logic [ppdm_pkg::US_W-1:0]   m_old;
  logic [QW-1:0]               m_quiet;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd15;
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Consume one multiplier bit per cycle, shift the multiplicands up.
  always_ff @(posedge clk) begin
    if (start) begin
      mr         <= prescaler;
      tr         <= ticks_per_us;
      m_new      <= ppdm_pkg::US_W'(cand_new);
      m_old      <= ppdm_pkg::US_W'(cand_old);
      m_quiet    <= QW'(quiet_us);
      prod_new   <= '0;
      prod_old   <= '0;
      prod_quiet <= '0;
    end else if (busy) begin
      mr      <= mr >> 1;
      tr      <= tr >> 1;
      m_new   <= m_new << 1;
      m_old   <= m_old << 1;
      m_quiet <= m_quiet << 1;
      if (mr[0]) begin
        prod_new <= prod_new + m_new;
        prod_old <= prod_old + m_old;
      end
      if (tr[0]) begin
        prod_quiet <= prod_quiet + m_quiet;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ppdm_div.sv @@
// Bit-serial restoring divider for the pulse meter: 32-bit dividend,
// 16-bit divisor, one quotient bit per cycle. Depends on ppdm_pkg.
`default_nettype none

module ppdm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ppdm_pkg::US_W-1:0]    dividend,
  input  wire logic [ppdm_pkg::TICK_W-1:0]  divisor,
  output logic      [ppdm_pkg::US_W-1:0]    quotient,
  output logic                              done
);

  logic                          busy;
  logic [4:0]                    cnt;
  logic [ppdm_pkg::TICK_W-1:0]   rem;
  logic [ppdm_pkg::TICK_W-1:0]   dvs;
  logic [ppdm_pkg::TICK_W:0]     trial;
  logic [ppdm_pkg::TICK_W:0]     diff;
  logic                          ge;

  assign trial = {rem, quotient[ppdm_pkg::US_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out of the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[ppdm_pkg::TICK_W-1:0] : trial[ppdm_pkg::TICK_W-1:0];
      quotient <= {quotient[ppdm_pkg::US_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ sv/pulse_period_duty_meter_quiet_window.sv @@
// Top level of one pulse meter channel: event intake, measurement state,
// control sequencer and result register. Uses ppdm_pkg, ppdm_mul, ppdm_div.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one event word: cmd 0 is an
//    edge capture (capture_value, high_ticks), cmd 1 is a counter overflow.
//  - Output channel (out_valid/out_ready) returns one word per event: the
//    latched period in ticks, duty in percent, period in microseconds and
//    the quiet-window flag, all as they stand after that event.
//  - Configuration: write cfg_data into register cfg_index when cfg_we is
//    high; 0 prescaler, 1 quiet_us, 2 ticks_per_us, 3 free_running.
//  - Sequence from acceptance to out_valid: load the multiplier, run the
//    16 multiplier steps (one prescaler bit a cycle), start the two
//    dividers, run the 32 divider steps side by side (one quotient bit a
//    cycle), latch the duty and write the result.
//  - Intake: a new event waits until the last is through; in_ready is high
//    only while the sequencer is idle, and that includes while an earlier result waits.
//  - Stall: a finished result sits in the output register; if it has not
//    been taken when the next one completes, the sequencer holds until it is.
//  - Reset clears the measurement state, the last capture and restores the
//    register defaults (prescaler 1101, ticks_per_us 84, others 0).
`default_nettype none

module pulse_period_duty_meter_quiet_window (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [ppdm_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic [ppdm_pkg::TICK_W-1:0]       capture_value,
  input  wire logic [ppdm_pkg::TICK_W-1:0]       high_ticks,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ppdm_pkg::TICK_W-1:0]       period_ticks,
  output logic      [ppdm_pkg::DUTY_W-1:0]       duty_percent,
  output logic      [ppdm_pkg::US_W-1:0]         period_us,
  output logic                                   in_quiet
);

  localparam int QW = ppdm_pkg::US_W + ppdm_pkg::TPU_W;
  localparam int HW = ppdm_pkg::TICK_W + 7;  // width of 100 * high

  // Configuration registers.
  logic [ppdm_pkg::PRE_W-1:0]  prescaler;
  logic [ppdm_pkg::US_W-1:0]   quiet_us;
  logic [ppdm_pkg::TPU_W-1:0]  ticks_per_us;
  logic                        free_running;

  // Measurement state.
  logic [ppdm_pkg::TICK_W-1:0] period_reg;
  logic [ppdm_pkg::DUTY_W-1:0] duty_reg;
  logic [ppdm_pkg::TICK_W-1:0] quiet_accum;
  logic [ppdm_pkg::TICK_W-1:0] last_capture;
  logic                        seen_capture;

  // Per-event working registers.
  logic [ppdm_pkg::TICK_W-1:0] total_r;
  logic [ppdm_pkg::TICK_W-1:0] high_r;
  logic                        take_r;
  logic                        latch_r;

  ppdm_pkg::state_t state, state_next;

  logic in_fire;
  logic out_free;
  logic mul_start;
  logic div_start;
  logic wb_load;

  logic [ppdm_pkg::TICK_W-1:0] period_in;
  logic [ppdm_pkg::TICK_W-1:0] total_in;

  logic [ppdm_pkg::US_W-1:0]   prod_new;
  logic [ppdm_pkg::US_W-1:0]   prod_old;
  logic [QW-1:0]               prod_quiet;
  logic                        mul_done;

  logic                        quiet_hit;
  logic                        latch_now;
  logic [HW-1:0]               high_x100;
  logic [ppdm_pkg::US_W-1:0]   duty_q;
  logic [ppdm_pkg::US_W-1:0]   us_q;
  logic                        duty_done;
  logic                        us_done;
  logic [ppdm_pkg::DUTY_W-1:0] duty_fix;

  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Free-running period wraps with the counter; reset mode gives it as is.
  assign period_in = free_running ? (capture_value - last_capture) : capture_value;
  assign total_in  = period_in + quiet_accum;

  // Window met when prescaler*total/tpu >= quiet_us, i.e. the product is at
  // least quiet_us*tpu. With tpu zero the conversion reads as zero.
  assign quiet_hit = (ticks_per_us == '0) ? (quiet_us == '0)
                                          : ({ppdm_pkg::TPU_W'(0), prod_new} >= prod_quiet);
  assign latch_now = take_r & quiet_hit;

  assign high_x100 = (HW'(high_r) << 6) + (HW'(high_r) << 5) + (HW'(high_r) << 2);

  // Cap the duty at full scale; an empty total gives zero duty.
  assign duty_fix = (total_r == '0) ? '0 :
                    (duty_q > ppdm_pkg::US_W'(ppdm_pkg::FULL_DUTY)) ? ppdm_pkg::FULL_DUTY :
                    duty_q[ppdm_pkg::DUTY_W-1:0];

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ppdm_pkg::S_IDLE: if (in_valid) state_next = ppdm_pkg::S_LOAD;
      ppdm_pkg::S_LOAD: state_next = ppdm_pkg::S_MUL;
      ppdm_pkg::S_MUL:  if (mul_done) state_next = ppdm_pkg::S_DIV;
      ppdm_pkg::S_DIV:  if (us_done & duty_done) state_next = ppdm_pkg::S_WB;
      ppdm_pkg::S_WB:   if (out_free) state_next = ppdm_pkg::S_IDLE;
      default:          state_next = ppdm_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    wb_load   = 1'b0;
    case (state)
      ppdm_pkg::S_IDLE: in_ready  = 1'b1;
      ppdm_pkg::S_LOAD: mul_start = 1'b1;
      ppdm_pkg::S_MUL:  div_start = mul_done;
      ppdm_pkg::S_DIV:  ;
      ppdm_pkg::S_WB:   wb_load   = out_free;
      default:          ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppdm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler    <= ppdm_pkg::PRE_W'(1101);
      quiet_us     <= '0;
      ticks_per_us <= ppdm_pkg::TPU_W'(84);
      free_running <= 1'b0;
    end else if (cfg_we) begin
      case (ppdm_pkg::cfg_reg_t'(cfg_index))
        ppdm_pkg::REG_PRESCALER:    prescaler    <= cfg_data[ppdm_pkg::PRE_W-1:0];
        ppdm_pkg::REG_QUIET_US:     quiet_us     <= cfg_data[ppdm_pkg::US_W-1:0];
        ppdm_pkg::REG_TICKS_PER_US: ticks_per_us <= cfg_data[ppdm_pkg::TPU_W-1:0];
        ppdm_pkg::REG_FREE_RUNNING: free_running <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg   <= '0;
      duty_reg     <= '0;
      quiet_accum  <= '0;
      last_capture <= '0;
      seen_capture <= 1'b0;
      take_r       <= 1'b0;
      latch_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        if (cmd) begin
          // Overflow: clear, but in free-running mode only after a silent span.
          take_r <= 1'b0;
          if (!free_running || !seen_capture) begin
            period_reg  <= '0;
            duty_reg    <= '0;
            quiet_accum <= '0;
          end
          if (free_running) begin
            seen_capture <= 1'b0;
          end
        end else begin
          take_r <= (period_in > ppdm_pkg::MIN_TICKS);
          if (free_running) begin
            last_capture <= capture_value;
            seen_capture <= 1'b1;
          end
        end
      end
      if (div_start) begin
        latch_r <= latch_now;
        if (latch_now) begin
          period_reg  <= total_r;
          quiet_accum <= '0;
        end else if (take_r) begin
          quiet_accum <= total_r;
        end
      end
      if (state == ppdm_pkg::S_DIV && us_done && latch_r) begin
        duty_reg <= duty_fix;
      end
    end
  end

  // Event payload: hold the total and the high time (zero in free-running mode) for the arithmetic.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      total_r <= total_in;
      high_r  <= free_running ? '0 : high_ticks;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_load) begin
      period_ticks <= period_reg;
      duty_percent <= duty_reg;
      period_us    <= (ticks_per_us == '0) ? '0 : us_q;
      in_quiet     <= (quiet_accum != '0);
    end
  end

  ppdm_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .prescaler    (prescaler),
    .cand_new     (total_r),
    .cand_old     (period_reg),
    .quiet_us     (quiet_us),
    .ticks_per_us (ticks_per_us),
    .prod_new     (prod_new),
    .prod_old     (prod_old),
    .prod_quiet   (prod_quiet),
    .done         (mul_done)
  );

  // Duty: 100 * high / total.
  ppdm_div u_div_duty (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ppdm_pkg::US_W'(high_x100)),
    .divisor  (total_r),
    .quotient (duty_q),
    .done     (duty_done)
  );

  // Microseconds: prescaler * period / ticks_per_us for the period that stands.
  ppdm_div u_div_us (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (latch_now ? prod_new : prod_old),
    .divisor  (ppdm_pkg::TICK_W'(ticks_per_us)),
    .quotient (us_q),
    .done     (us_done)
  );

endmodule

`default_nettype wire
